// File: hw/rtl/acb_pkg.sv
package acb_pkg;

  // Command queue between front and back
  localparam int unsigned CmdDepth = 4;
  localparam int unsigned CmdPtrW  = $clog2(CmdDepth);
  localparam int unsigned CmdCntW  = $clog2(CmdDepth + 1);

  // Line byte counter, saturating
  localparam int unsigned BwWidth = 17;
  localparam logic [BwWidth-1:0] BwMax = '1;

  // Longest padding burst: 63 results of three bytes
  localparam logic [7:0] PadMaxBytes = 8'd189;
  localparam logic [1:0] FullCount   = 2'd3;

  typedef enum logic [1:0] {
    CfgBg0       = 2'd0,
    CfgBg1       = 2'd1,
    CfgBg2       = 2'd2,
    CfgLineBytes = 2'd3
  } cfg_idx_e;

  localparam logic KindPixel   = 1'b0;
  localparam logic KindLineEnd = 1'b1;

  typedef struct packed {
    logic       kind;
    logic [7:0] fg_channel0;
    logic [7:0] fg_channel1;
    logic [7:0] fg_channel2;
    logic [7:0] alpha;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte0;
    logic [7:0] out_byte1;
    logic [7:0] out_byte2;
    logic [1:0] byte_count;
    logic       line_end;
    logic       pad_truncated;
  } out_item_t;

  // Classified item handed from front to back
  typedef struct packed {
    logic       line_end;
    logic [7:0] fg0;
    logic [7:0] fg1;
    logic [7:0] fg2;
    logic [7:0] alpha;
    logic [7:0] pad_bytes;
    logic       pad_trunc;
  } cmd_t;

  typedef struct packed {
    logic [7:0] bg0;
    logic [7:0] bg1;
    logic [7:0] bg2;
  } bg_t;

  // floor(n / 255) for n below 65280, without a divider
  function automatic logic [7:0] div255(input logic [16:0] n);
    logic [16:0] t;
    t = n + {8'd0, n[16:8]} + 17'd1;
    return t[15:8];
  endfunction

endpackage

// File: hw/rtl/acb_front.sv
module acb_front import acb_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  in_item_t  in_item_i,
  input  logic [15:0] line_bytes_i,
  input  logic      cmd_full_i,
  output logic      cmd_push_o,
  output cmd_t      cmd_o
);

  logic [BwWidth-1:0] bw_q, bw_d;
  logic [BwWidth-1:0] line_ext, diff;
  logic [BwWidth:0]   bw_sum;
  logic               accept, gt, trunc;

  assign accept     = push_i && !cmd_full_i;
  assign cmd_push_o = accept;

  // Work out the padding left on this line
  assign line_ext = {1'b0, line_bytes_i};
  assign gt       = line_ext > bw_q;
  assign diff     = line_ext - bw_q;
  assign trunc    = gt && (diff > {9'd0, PadMaxBytes});

  always_comb begin
    cmd_o.line_end  = (in_item_i.kind == KindLineEnd);
    cmd_o.fg0       = in_item_i.fg_channel0;
    cmd_o.fg1       = in_item_i.fg_channel1;
    cmd_o.fg2       = in_item_i.fg_channel2;
    cmd_o.alpha     = in_item_i.alpha;
    cmd_o.pad_trunc = trunc;
    if (!gt) begin
      cmd_o.pad_bytes = 8'd0;
    end else if (trunc) begin
      cmd_o.pad_bytes = PadMaxBytes;
    end else begin
      cmd_o.pad_bytes = diff[7:0];
    end
  end

  // Count line bytes, saturate, clear at line end
  assign bw_sum = {1'b0, bw_q} + {{(BwWidth-1){1'b0}}, 2'd3};

  always_comb begin
    bw_d = bw_q;
    if (accept) begin
      if (in_item_i.kind == KindLineEnd) begin
        bw_d = '0;
      end else if (bw_sum[BwWidth]) begin
        bw_d = BwMax;
      end else begin
        bw_d = bw_sum[BwWidth-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bw_q <= '0;
    end else begin
      bw_q <= bw_d;
    end
  end

endmodule

// File: hw/rtl/acb_cmd_fifo.sv
module acb_cmd_fifo import acb_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t data_i,
  input  logic pop_i,
  output cmd_t head_o,
  output logic full_o,
  output logic empty_o
);

  cmd_t               mem_q [CmdDepth];
  logic [CmdPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CmdCntW-1:0] cnt_q;
  logic               do_push, do_pop;

  assign full_o  = (cnt_q == CmdCntW'(CmdDepth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign head_o  = mem_q[rd_ptr_q];

  // Store the incoming transaction
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + CmdPtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + CmdPtrW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CmdCntW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CmdCntW'(1);
      end
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CmdCntW'(CmdDepth))
    else $error("command queue occupancy overflow");

  a_cnt_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (do_push && !do_pop) |=> (cnt_q == $past(cnt_q) + CmdCntW'(1)))
    else $error("command queue occupancy lost a push");

endmodule

// File: hw/rtl/acb_back.sv
module acb_back import acb_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      cmd_empty_i,
  input  cmd_t      cmd_i,
  input  bg_t       bg_i,
  input  logic      pop_i,
  output logic      cmd_pop_o,
  output out_item_t out_item_o,
  output logic      empty_o
);

  // Stage 1: products or padding result
  logic        s1_v_q, s1_pix_q;
  logic [15:0] s1_pf_q [3];
  logic [15:0] s1_pb_q [3];
  logic [1:0]  s1_cnt_q;
  logic        s1_end_q, s1_trunc_q;

  // Stage 2: output register
  logic      s2_v_q;
  out_item_t s2_q, s2_d;

  // Padding sequencer
  logic       pad_busy_q, pad_busy_d;
  logic [7:0] rem_q, rem_d;
  logic [7:0] cur_rem, inv_alpha;
  logic       s2_ld, s1_adv, take, pad_last;
  logic [1:0] pad_cnt;

  assign s2_ld  = !s2_v_q || pop_i;
  assign s1_adv = !s1_v_q || s2_ld;
  assign take   = s1_adv && !cmd_empty_i;

  assign cur_rem   = pad_busy_q ? rem_q : cmd_i.pad_bytes;
  assign pad_last  = (cur_rem <= 8'd3);
  assign pad_cnt   = pad_last ? cur_rem[1:0] : FullCount;
  assign inv_alpha = 8'd255 - cmd_i.alpha;

  // Release a pixel at once, a line end after its last result
  assign cmd_pop_o = take && (!cmd_i.line_end || pad_last);

  always_comb begin
    pad_busy_d = pad_busy_q;
    rem_d      = rem_q;
    if (take && cmd_i.line_end) begin
      pad_busy_d = !pad_last;
      rem_d      = cur_rem - 8'd3;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pad_busy_q <= 1'b0;
      s1_v_q     <= 1'b0;
      s2_v_q     <= 1'b0;
    end else begin
      pad_busy_q <= pad_busy_d;
      if (s1_adv) begin
        s1_v_q <= !cmd_empty_i;
      end
      if (s2_ld) begin
        s2_v_q <= s1_v_q;
      end
    end
  end

  // Multiply foreground and background by their weights; keep padding fields
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    if (take) begin
      s1_pix_q   <= !cmd_i.line_end;
      s1_pf_q[0] <= cmd_i.fg0 * cmd_i.alpha;
      s1_pf_q[1] <= cmd_i.fg1 * cmd_i.alpha;
      s1_pf_q[2] <= cmd_i.fg2 * cmd_i.alpha;
      s1_pb_q[0] <= bg_i.bg0 * inv_alpha;
      s1_pb_q[1] <= bg_i.bg1 * inv_alpha;
      s1_pb_q[2] <= bg_i.bg2 * inv_alpha;
      s1_cnt_q   <= pad_cnt;
      s1_end_q   <= pad_last;
      s1_trunc_q <= cmd_i.pad_trunc;
    end
  end

  // Pixel: sum, round and divide by 255; otherwise a zero padding result
  always_comb begin
    if (s1_pix_q) begin
      s2_d.out_byte0     = div255({1'b0, s1_pf_q[0]} + {1'b0, s1_pb_q[0]} + 17'd127);
      s2_d.out_byte1     = div255({1'b0, s1_pf_q[1]} + {1'b0, s1_pb_q[1]} + 17'd127);
      s2_d.out_byte2     = div255({1'b0, s1_pf_q[2]} + {1'b0, s1_pb_q[2]} + 17'd127);
      s2_d.byte_count    = FullCount;
      s2_d.line_end      = 1'b0;
      s2_d.pad_truncated = 1'b0;
    end else begin
      s2_d.out_byte0     = 8'd0;
      s2_d.out_byte1     = 8'd0;
      s2_d.out_byte2     = 8'd0;
      s2_d.byte_count    = s1_cnt_q;
      s2_d.line_end      = s1_end_q;
      s2_d.pad_truncated = s1_trunc_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_ld) begin
      s2_q <= s2_d;
    end
  end

  assign out_item_o = s2_q;
  assign empty_o    = !s2_v_q;

  a_trunc_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s2_v_q && s2_q.pad_truncated) |-> (s2_q.byte_count == FullCount))
    else $error("truncated padding result is not full");

  a_short_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s2_v_q && s2_q.byte_count != FullCount) |-> s2_q.line_end)
    else $error("short result does not end the line");

  a_no_mix: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take && !cmd_i.line_end) |-> !pad_busy_q)
    else $error("pixel taken inside a padding burst");

endmodule

// File: hw/rtl/alpha_composite_over_background_core.sv
// Composites RGBA pixels over a constant background color, three bytes
// per result, and pads each line with zero bytes toward line_bytes (189 max).
// Input queue side: drive in_item_i and push; the transaction is taken at
// a clock edge with push high and full low. kind 0 carries a pixel, kind 1
// closes the line.
// Output queue side: while empty is low the oldest result sits on
// out_item_o; pop high at a clock edge takes it.
// Configuration: cfg_we_i writes cfg_wdata_i into register cfg_idx_i
// (0..2 background bytes, 3 line length in bytes); write only while idle.
// An item passes the command queue, the multiply stage and the output stage.
// Throughput: one pixel per cycle while pop keeps up; a line end makes
// 1 to 63 results in turn, set by the padding sequencer in the back end.
// A four-entry command queue sits between the front end and the back end.
// Reset: background 255/255/255, line length 0, line byte count 0, queues
// empty. When pop stays low the output register and the multiply stage
// hold; the command queue then fills and full rises.
module alpha_composite_over_background_core import acb_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  in_item_t    in_item_i,
  output logic        empty,
  input  logic        pop,
  output out_item_t   out_item_o,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_wdata_i
);

  bg_t         bg_q;
  logic [15:0] line_bytes_q;
  logic        cmd_push, cmd_pop, cmd_full, cmd_empty;
  cmd_t        cmd_in, cmd_head;

  // Hold configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bg_q.bg0     <= 8'd255;
      bg_q.bg1     <= 8'd255;
      bg_q.bg2     <= 8'd255;
      line_bytes_q <= 16'd0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgBg0:       bg_q.bg0     <= cfg_wdata_i[7:0];
        CfgBg1:       bg_q.bg1     <= cfg_wdata_i[7:0];
        CfgBg2:       bg_q.bg2     <= cfg_wdata_i[7:0];
        CfgLineBytes: line_bytes_q <= cfg_wdata_i;
      endcase
    end
  end

  assign full = cmd_full;

  acb_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .in_item_i    (in_item_i),
    .line_bytes_i (line_bytes_q),
    .cmd_full_i   (cmd_full),
    .cmd_push_o   (cmd_push),
    .cmd_o        (cmd_in)
  );

  acb_cmd_fifo u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .data_i  (cmd_in),
    .pop_i   (cmd_pop),
    .head_o  (cmd_head),
    .full_o  (cmd_full),
    .empty_o (cmd_empty)
  );

  acb_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_empty_i (cmd_empty),
    .cmd_i       (cmd_head),
    .bg_i        (bg_q),
    .pop_i       (pop),
    .cmd_pop_o   (cmd_pop),
    .out_item_o  (out_item_o),
    .empty_o     (empty)
  );

endmodule
